@@ rtl/core/sha256_pkg.sv @@
`default_nettype none
package sha256_pkg;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned RoundCount = 64;

	// one classified item travelling from the front to the back
	typedef struct packed {
		logic       finish;
		logic [7:0] data;
	} cmd_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] START_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/sha256_queue.sv @@
`default_nettype none
// Front end: takes input transfers and queues them as commands for the back end
module sha256_queue
	import sha256_pkg::*;
#(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid,
	output logic            ready,
	input  wire logic       mode,
	input  wire logic [7:0] byte_value,
	output logic            cmd_valid,
	input  wire logic       cmd_ready,
	output cmd_t            cmd
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign ready     = (cnt_q != (AW+1)'(DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = mem_q[rd_q];
	assign push      = valid && ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{finish: mode, data: byte_value};
		end
	end

	// pointers wrap at the depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/sha256_engine.sv @@
`default_nettype none
// Back end: block buffer, padding, 64-round compression and digest output
module sha256_engine
	import sha256_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PAD   = 6'b000010,
		S_LOAD  = 6'b000100,
		S_ROUND = 6'b001000,
		S_ADD   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t       state_q;
	logic [31:0]  buf_q [16];  // block buffer as 16 big-endian words
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [5:0]   fill_q;
	logic [60:0]  len_q;
	logic [5:0]   rnd_q;
	logic         fin_q;     // compressing the final block
	logic         two_q;     // a second padding block follows
	logic [2:0]   idx_q;
	logic [63:0]  bits;

	// one round of the compression, schedule taken from the 16-word window
	logic [31:0]  wt, w15, w2, t1, t2, e, a;
	logic [3:0]   ri;

	assign ri  = rnd_q[3:0];
	assign w15 = w_q[ri + 4'd1];
	assign w2  = w_q[ri + 4'd14];
	assign e   = v_q[4];
	assign a   = v_q[0];
	assign bits = {len_q, 3'b000};

	always_comb begin
		if (rnd_q < 6'd16) begin
			wt = buf_q[ri];
		end else begin
			wt = w_q[ri] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w_q[ri + 4'd9]
				+ (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
		end
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v_q[5]) ^ (~e & v_q[6]))
			+ ROUND_K[rnd_q] + wt;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign cmd_ready   = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			len_q   <= '0;
			rnd_q   <= '0;
			fin_q   <= 1'b0;
			two_q   <= 1'b0;
			idx_q   <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= START_H[i];
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (!cmd.finish) begin
							buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= cmd.data;
							fill_q        <= fill_q + 6'd1;
							len_q         <= len_q + 61'd1;
							fin_q         <= 1'b0;
							if (fill_q == 6'd63) state_q <= S_LOAD;
						end else begin
							buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= 8'h80;
							fill_q        <= fill_q + 6'd1;
							two_q         <= (fill_q >= 6'd56);
							state_q       <= S_PAD;
						end
					end
				end
				// zero one byte per cycle; length goes into bytes 56..63
				S_PAD: begin
					if (fill_q == 6'd0) begin
						fin_q   <= !two_q;
						state_q <= S_LOAD;
					end else if (!two_q && fill_q >= 6'd56) begin
						buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <=
							bits[8*(63 - fill_q) +: 8];
						fill_q        <= fill_q + 6'd1;
					end else begin
						buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= 8'h00;
						fill_q        <= fill_q + 6'd1;
					end
				end
				S_LOAD: begin
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					w_q[ri] <= wt;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 6'd1;
					if (rnd_q == 6'(RoundCount - 1)) state_q <= S_ADD;
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (fin_q) begin
						idx_q   <= '0;
						state_q <= S_OUT;
					end else if (two_q) begin
						// second padding block: byte 0 zeroed here, rest in S_PAD
						buf_q[0][31:24] <= 8'h00;
						fill_q  <= 6'd1;
						two_q   <= 1'b0;
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= START_H[i];
							len_q   <= '0;
							fill_q  <= '0;
							fin_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/sha256_stream_hasher_core.sv @@
`default_nettype none
// SHA-256 over a byte stream. A transfer with mode 0 appends byte_value to the
// message; mode 1 pads, finishes and returns eight digest words, index 0 first,
// last_word on the eighth, then starts a fresh message. A short command queue
// takes bytes while the back end works. The back end takes one byte per cycle
// when idle and, on the 64th byte of a block, compresses it in its single shared round
// unit (one round per cycle). A finish writes the 0x80 byte, then pads the rest of the
// block a byte at a time, with the bit length in bytes 56..63; when the length does not
// fit, a second padding block follows the first compression. Then come one or two
// compressions and eight output transfers.
module sha256_stream_hasher_core
	import sha256_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [7:0]  byte_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .valid(in_valid), .ready(in_ready), .mode, .byte_value,
		.cmd_valid, .cmd_ready, .cmd
	);

	sha256_engine u_engine (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.out_valid, .out_ready, .digest_word, .word_index, .last_word
	);
endmodule
`default_nettype wire

@@ tb/sv/tb_sha256_stream_hasher_core.sv @@
`default_nettype none
module tb_sha256_stream_hasher_core;
	import sha256_pkg::*;

	typedef struct {
		logic       fin;
		logic [7:0] data;
	} byte_cmd_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = 1'b0;
	logic [7:0]  byte_value = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	byte_cmd_t    cmd_q[$];
	digest_beat_t digest_q[$];
	int unsigned  n_errors = 0;
	int unsigned  cycle_cnt = 0;
	logic         calm = 1'b0;
	logic         hold_req = 1'b0;
	logic         hold_done = 1'b0;
	int unsigned  hold_left = 0;

	// hasher state kept by the predictor
	logic [31:0] chain_h[8];
	logic [7:0]  blk_buf[64];
	int unsigned blk_fill;
	logic [60:0] msg_bytes;

	sha256_stream_hasher_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .byte_value(byte_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	always #10 clk = ~clk;

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 300000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of the current block into the chaining words
	task automatic compress_block();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = chain_h[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
	endtask

	task automatic restart_message();
		for (int i = 0; i < 8; i++) chain_h[i] = START_H[i];
		blk_fill = 0;
		msg_bytes = '0;
	endtask

	// absorb a byte, or pad and queue the eight digest words
	task automatic hash_step(input logic fin, input logic [7:0] data);
		logic [63:0]  bit_len;
		digest_beat_t beat;
		if (!fin) begin
			blk_buf[blk_fill] = data;
			msg_bytes = msg_bytes + 1'b1;
			blk_fill = (blk_fill + 1) % 64;
			if (blk_fill == 0) compress_block();
		end else begin
			blk_buf[blk_fill] = 8'h80;
			blk_fill++;
			if (blk_fill > 56) begin
				while (blk_fill < 64) begin
					blk_buf[blk_fill] = 8'h00;
					blk_fill++;
				end
				compress_block();
				blk_fill = 0;
			end
			while (blk_fill < 56) begin
				blk_buf[blk_fill] = 8'h00;
				blk_fill++;
			end
			bit_len = {msg_bytes, 3'b000};
			for (int i = 0; i < 8; i++) blk_buf[56+i] = bit_len[63-8*i -: 8];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				beat.word = chain_h[i];
				beat.idx = 3'(i);
				beat.last = (i == 7);
				digest_q.push_back(beat);
			end
			restart_message();
		end
	endtask

	task automatic flag_error(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
		n_errors++;
		if (n_errors <= 10)
			$display("mismatch %s: expected %h got %h at cycle %0d", what, exp_v, got_v, cycle_cnt);
	endtask

	// driver: presents queued items, predicts on each transfer
	always @(posedge clk or negedge arst_n) begin
		logic      nxt_valid;
		byte_cmd_t cmd;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nxt_valid = in_valid;
			if (in_valid && in_ready) begin
				hash_step(mode, byte_value);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && cmd_q.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
				cmd = cmd_q.pop_front();
				mode <= cmd.fin;
				byte_value <= cmd.data;
				nxt_valid = 1'b1;
			end
			in_valid <= nxt_valid;
		end
	end

	// monitor: checks digest transfers, drives out_ready
	always @(posedge clk or negedge arst_n) begin
		digest_beat_t beat;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					flag_error("unexpected digest word", 32'h0, digest_word);
				end else begin
					beat = digest_q.pop_front();
					if (digest_word !== beat.word) flag_error("digest_word", beat.word, digest_word);
					if (word_index !== beat.idx)
						flag_error("word_index", 32'(beat.idx), 32'(word_index));
					if (last_word !== beat.last)
						flag_error("last_word", 32'(beat.last), 32'(last_word));
				end
			end
			if (hold_req && !hold_done) begin
				hold_left = 400;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 30);
			end
		end
	end

	task automatic push_cmd(input logic fin, input logic [7:0] data);
		byte_cmd_t c;
		c.fin = fin;
		c.data = data;
		cmd_q.push_back(c);
	endtask

	task automatic wait_drained();
		while (cmd_q.size() > 0 || in_valid || digest_q.size() > 0) @(posedge clk);
	endtask

	initial begin
		int unsigned total;
		int unsigned len;
		int unsigned pick;
		restart_message();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, "abc", extreme bytes, finish with ignored byte set
		push_cmd(1'b1, 8'h00);
		push_cmd(1'b0, 8'h61); push_cmd(1'b0, 8'h62); push_cmd(1'b0, 8'h63);
		push_cmd(1'b1, 8'h00);
		push_cmd(1'b0, 8'h00); push_cmd(1'b0, 8'hff); push_cmd(1'b1, 8'hff);
		push_cmd(1'b0, 8'hff); push_cmd(1'b1, 8'h5a);
		push_cmd(1'b1, 8'hff);
		wait_drained();

		// random messages; lengths near the padding boundaries now and then
		hold_req = 1'b1;
		total = 0;
		while (total < 110) begin
			pick = $urandom_range(3);
			if (pick == 0) begin
				case ($urandom_range(4))
					0: len = 55;
					1: len = 56;
					2: len = 63;
					3: len = 64;
					default: len = 65;
				endcase
			end else begin
				len = $urandom_range(12);
			end
			for (int i = 0; i < len; i++) push_cmd(1'b0, 8'($urandom_range(255)));
			push_cmd(1'b1, 8'($urandom_range(255)));
			total += len + 1;
		end

		// a stretch without idling on either side
		while (cmd_q.size() > total / 2) @(posedge clk);
		calm = 1'b1;
		while (cmd_q.size() > total / 4) @(posedge clk);
		calm = 1'b0;

		wait_drained();
		repeat (200) @(posedge clk);
		if (n_errors == 0 && digest_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/sha256_pkg.sv
rtl/core/sha256_queue.sv
rtl/core/sha256_engine.sv
rtl/core/sha256_stream_hasher_core.sv
tb/sv/tb_sha256_stream_hasher_core.sv
